// ===== rtl/etc_pkg.sv =====
`default_nettype none

package etc_pkg;

  localparam logic [1:0] CMD_WRITE_TENSOR  = 2'd0;
  localparam logic [1:0] CMD_WRITE_OPERAND = 2'd1;
  localparam logic [1:0] CMD_CONTRACT      = 2'd2;
  localparam logic [1:0] CMD_JACOBIAN      = 2'd3;

  typedef struct packed {
    logic        [1:0]  command;
    logic        [1:0]  idx_first;
    logic        [1:0]  idx_second;
    logic        [1:0]  idx_third;
    logic        [1:0]  idx_fourth;
    logic signed [31:0] entry_value;
    logic signed [31:0] test_grad_x;
    logic signed [31:0] test_grad_y;
    logic signed [31:0] test_grad_z;
    logic signed [31:0] shape_grad_x;
    logic signed [31:0] shape_grad_y;
    logic signed [31:0] shape_grad_z;
  } request_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic        [1:0]  result_row;
    logic        [1:0]  result_col;
    logic               last;
  } result_t;

  // store write controls
  typedef struct packed {
    logic               tensor_we;
    logic               operand_we;
    logic signed [31:0] value;
  } store_write_t;

  // one multiply-accumulate term, issued alongside the store read
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               group_end;
    logic               final_term;
    logic               jac;
    logic               add;
    logic        [1:0]  row;
    logic        [1:0]  col;
    logic signed [31:0] shape;
    logic signed [31:0] test;
  } issue_t;

endpackage

`default_nettype wire

// ===== rtl/etc_store.sv =====
`default_nettype none

module etc_store #(
  parameter  int DIM    = 3,
  localparam int TDEPTH = DIM * DIM * DIM * DIM,
  localparam int ODEPTH = DIM * DIM,
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1,
  localparam int OAW    = (ODEPTH > 1) ? $clog2(ODEPTH) : 1
) (
  input  wire                       clk,
  input  etc_pkg::store_write_t     wr,
  input  wire [TAW-1:0]             t_waddr,
  input  wire [OAW-1:0]             o_waddr,
  input  wire [TAW-1:0]             t_raddr,
  input  wire [OAW-1:0]             o_raddr,
  output logic signed [31:0]        tdata,
  output logic signed [31:0]        odata
);

  logic [31:0] tmem [TDEPTH];
  logic [31:0] omem [ODEPTH];

  always_ff @(posedge clk) begin
    if (wr.tensor_we) begin
      tmem[t_waddr] <= wr.value;
    end
    tdata <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.operand_we) begin
      omem[o_waddr] <= wr.value;
    end
    odata <= omem[o_raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/etc_seq.sv =====
`default_nettype none

module etc_seq #(
  parameter  int DIM    = 3,
  localparam int TDEPTH = DIM * DIM * DIM * DIM,
  localparam int ODEPTH = DIM * DIM,
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1,
  localparam int OAW    = (ODEPTH > 1) ? $clog2(ODEPTH) : 1
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  etc_pkg::request_t         request,
  input  wire                       finishing,
  output logic                      busy,
  output etc_pkg::store_write_t     wr,
  output logic [TAW-1:0]            t_waddr,
  output logic [OAW-1:0]            o_waddr,
  output logic [TAW-1:0]            t_raddr,
  output logic [OAW-1:0]            o_raddr,
  output etc_pkg::issue_t           issue
);

  localparam logic [1:0] LAST = 2'(DIM - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  logic               jac;
  logic               range_ok;
  logic [1:0]         ri, rk;
  logic [1:0]         o1, o2, n1, n2;
  logic signed [31:0] tg_x, tg_y, tg_z, sg_x, sg_y, sg_z;

  logic       accept, compute_cmd, final_term, group_end;
  logic [1:0] x0, x1, x2, x3;

  function automatic logic in_range(input logic [1:0] v);
    return {1'b0, v} < 3'(DIM);
  endfunction

  function automatic logic [TAW-1:0] t_index(input logic [1:0] a, input logic [1:0] b,
                                             input logic [1:0] c, input logic [1:0] d);
    return TAW'(((int'(a) * DIM + int'(b)) * DIM + int'(c)) * DIM + int'(d));
  endfunction

  function automatic logic [OAW-1:0] o_index(input logic [1:0] c, input logic [1:0] d);
    return OAW'(int'(c) * DIM + int'(d));
  endfunction

  function automatic logic signed [31:0] grad_pick(input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z,
                                                   input logic [1:0] sel);
    logic signed [31:0] r;
    unique case (sel)
      2'd0:    r = x;
      2'd1:    r = y;
      2'd2:    r = z;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign compute_cmd = (request.command == etc_pkg::CMD_CONTRACT) ||
                       (request.command == etc_pkg::CMD_JACOBIAN);

  // write commands complete in the transfer cycle
  always_comb begin
    wr.value      = request.entry_value;
    wr.tensor_we  = accept && (request.command == etc_pkg::CMD_WRITE_TENSOR) &&
                    in_range(request.idx_first) && in_range(request.idx_second) &&
                    in_range(request.idx_third) && in_range(request.idx_fourth);
    wr.operand_we = accept && (request.command == etc_pkg::CMD_WRITE_OPERAND) &&
                    in_range(request.idx_third) && in_range(request.idx_fourth);
    t_waddr = t_index(request.idx_first, request.idx_second,
                      request.idx_third, request.idx_fourth);
    o_waddr = o_index(request.idx_third, request.idx_fourth);
  end

  assign group_end  = (n1 == LAST) && (n2 == LAST);
  assign final_term = group_end && (jac || ((o1 == LAST) && (o2 == LAST)));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && compute_cmd) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (final_term) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (finishing) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && compute_cmd) begin
      jac      <= (request.command == etc_pkg::CMD_JACOBIAN);
      ri       <= request.idx_first;
      rk       <= request.idx_third;
      range_ok <= in_range(request.idx_first) && in_range(request.idx_third);
      tg_x     <= request.test_grad_x;
      tg_y     <= request.test_grad_y;
      tg_z     <= request.test_grad_z;
      sg_x     <= request.shape_grad_x;
      sg_y     <= request.shape_grad_y;
      sg_z     <= request.shape_grad_z;
      o1       <= '0;
      o2       <= '0;
      n1       <= '0;
      n2       <= '0;
    end else if (state == S_RUN) begin
      if (n2 != LAST) begin
        n2 <= n2 + 2'd1;
      end else begin
        n2 <= '0;
        if (n1 != LAST) begin
          n1 <= n1 + 2'd1;
        end else begin
          n1 <= '0;
          if (o2 != LAST) begin
            o2 <= o2 + 2'd1;
          end else begin
            o2 <= '0;
            o1 <= o1 + 2'd1;
          end
        end
      end
    end
  end

  // contract walks (o1,o2,n1,n2); jacobian walks (i,n1,k,n2)
  always_comb begin
    if (jac) begin
      x0 = range_ok ? ri : 2'd0;
      x1 = n1;
      x2 = range_ok ? rk : 2'd0;
      x3 = n2;
    end else begin
      x0 = o1;
      x1 = o2;
      x2 = n1;
      x3 = n2;
    end
    t_raddr = t_index(x0, x1, x2, x3);
    o_raddr = o_index(n1, n2);
  end

  always_comb begin
    issue.valid      = (state == S_RUN);
    issue.first      = (n1 == 2'd0) && (n2 == 2'd0);
    issue.group_end  = group_end;
    issue.final_term = final_term;
    issue.jac        = jac;
    issue.add        = !jac || range_ok;
    issue.row        = jac ? ri : o1;
    issue.col        = jac ? rk : o2;
    issue.shape      = grad_pick(sg_x, sg_y, sg_z, n2);
    issue.test       = grad_pick(tg_x, tg_y, tg_z, n1);
  end

endmodule

`default_nettype wire

// ===== rtl/etc_mac.sv =====
`default_nettype none

module etc_mac (
  input  wire                       clk,
  input  wire                       rst,
  input  etc_pkg::issue_t           issue,
  input  wire signed [31:0]         tdata,
  input  wire signed [31:0]         odata,
  output logic                      finishing,
  output logic                      strobe,
  output etc_pkg::result_t          result
);

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(x);
    end
    return r;
  endfunction

  etc_pkg::issue_t    t1, t2, t3, t4;
  logic signed [63:0] prod1, term3, val4, acc;
  logic signed [31:0] p3;
  logic signed [31:0] opb;
  logic signed [63:0] sh1, term5, sum;

  assign opb = t1.jac ? t1.shape : odata;
  assign sh1 = prod1 >>> 16;

  always_comb begin
    if (!t4.add) begin
      term5 = '0;
    end else if (t4.jac) begin
      term5 = val4 >>> 16;
    end else begin
      term5 = val4;
    end
    sum = (t4.first ? 64'sd0 : acc) + term5;
  end

  assign finishing = t4.valid && t4.final_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      t4.valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      t1     <= issue;
      t2     <= t1;
      t3     <= t2;
      t4     <= t3;
      strobe <= t4.valid && t4.group_end;
    end
  end

  // datapath: product, floor shift, for a jacobian saturate, second product and shift, accumulate, saturate the result
  always_ff @(posedge clk) begin
    prod1 <= tdata * opb;
    term3 <= sh1;
    p3    <= sat32(sh1);
    val4  <= t3.jac ? (p3 * t3.test) : term3;
    if (t4.valid) begin
      acc <= sum;
    end
    result.result_value <= sat32(sum);
    result.result_row   <= t4.row;
    result.result_col   <= t4.col;
    result.last         <= t4.final_term;
  end

endmodule

`default_nettype wire

// ===== rtl/elasticity_tensor_contraction.sv =====
`default_nettype none

// Stiffness tensor engine: holds a DIM^4 tensor and a DIM x DIM operand in on-chip memories
// and runs one multiply-accumulate term per cycle. A command transfers when start is high
// and busy is low. Tensor and operand writes keep busy low and complete in the transfer
// cycle. A contraction keeps busy high while the single tensor memory read port walks all
// DIM^4 entries and the pipeline drains, and a jacobian while it walks DIM^2 entries. Each
// result is shown on result for exactly one cycle, marked by strobe; the nine contraction
// results of a 3 x 3 run come out row-major, and last marks the final one. There is no
// backpressure: results must be taken when strobe is high.
module elasticity_tensor_contraction #(
  parameter int DIM = 3
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  etc_pkg::request_t     request,
  output logic                  busy,
  output logic                  strobe,
  output etc_pkg::result_t      result
);

  localparam int TDEPTH = DIM * DIM * DIM * DIM;
  localparam int ODEPTH = DIM * DIM;
  localparam int TAW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int OAW = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;

  etc_pkg::store_write_t wr;
  etc_pkg::issue_t       issue;
  logic [TAW-1:0]        t_waddr, t_raddr;
  logic [OAW-1:0]        o_waddr, o_raddr;
  logic signed [31:0]    tdata, odata;
  logic                  finishing;

  etc_seq #(
    .DIM (DIM)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .finishing (finishing),
    .busy      (busy),
    .wr        (wr),
    .t_waddr   (t_waddr),
    .o_waddr   (o_waddr),
    .t_raddr   (t_raddr),
    .o_raddr   (o_raddr),
    .issue     (issue)
  );

  etc_store #(
    .DIM (DIM)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .t_waddr (t_waddr),
    .o_waddr (o_waddr),
    .t_raddr (t_raddr),
    .o_raddr (o_raddr),
    .tdata   (tdata),
    .odata   (odata)
  );

  etc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .tdata     (tdata),
    .odata     (odata),
    .finishing (finishing),
    .strobe    (strobe),
    .result    (result)
  );

`ifndef SYNTH
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy)
    else $error("final result shown while still busy");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && ((request.command == etc_pkg::CMD_WRITE_TENSOR) ||
                       (request.command == etc_pkg::CMD_WRITE_OPERAND)) |=> !strobe)
    else $error("result strobe after a write transfer");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && ((request.command == etc_pkg::CMD_CONTRACT) ||
                       (request.command == etc_pkg::CMD_JACOBIAN)) |=> busy)
    else $error("compute command did not raise busy");

  a_no_strobe_idle_run: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe)
    else $error("result strobe with no command in flight");
`endif

endmodule

`default_nettype wire

// ===== tb/elasticity_tensor_contraction_tb.sv =====
`timescale 1ns / 1ps

module elasticity_tensor_contraction_tb;

  localparam int DIM = 3;
  localparam int N_RANDOM = 210;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 100;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef struct {
    etc_pkg::request_t  req;
    bit                 typed;
    logic signed [31:0] value;
  } stim_step_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  etc_pkg::request_t request = '0;
  logic              busy;
  logic              strobe;
  etc_pkg::result_t  result;

  // expectation typed into the directed steps, travels with the request
  bit                 step_typed = 1'b0;
  logic signed [31:0] step_value = '0;

  logic signed [31:0] stiffness_mem [DIM*DIM*DIM*DIM];
  logic signed [31:0] operand_mem [DIM*DIM];
  etc_pkg::result_t   pending_results [$];
  stim_step_t         directed_steps [$];

  int errors = 0;
  int quiet = 0;
  int burst_left = 0;
  int n_writes = 0;
  int n_contracts = 0;
  int n_jacobians = 0;
  int n_outside = 0;
  int n_checked = 0;

  elasticity_tensor_contraction #(.DIM(DIM)) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #2 clk = ~clk;

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > longint'(Q_MAX)) return Q_MAX;
    if (x < longint'(Q_MIN)) return Q_MIN;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: return Q_MAX;
          1: return Q_MIN;
          default: return '0;
        endcase
      end
      1, 2: return $urandom;
      default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  function automatic logic [1:0] rand_idx();
    return ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, DIM - 1));
  endfunction

  function automatic etc_pkg::request_t mk_req(input logic [1:0] cmd, input logic [1:0] i,
                                               input logic [1:0] j, input logic [1:0] k,
                                               input logic [1:0] l,
                                               input logic signed [31:0] ev,
                                               input logic signed [31:0] tx,
                                               input logic signed [31:0] ty,
                                               input logic signed [31:0] tz,
                                               input logic signed [31:0] sx,
                                               input logic signed [31:0] sy,
                                               input logic signed [31:0] sz);
    etc_pkg::request_t r;
    r.command = cmd;
    r.idx_first = i;
    r.idx_second = j;
    r.idx_third = k;
    r.idx_fourth = l;
    r.entry_value = ev;
    r.test_grad_x = tx;
    r.test_grad_y = ty;
    r.test_grad_z = tz;
    r.shape_grad_x = sx;
    r.shape_grad_y = sy;
    r.shape_grad_z = sz;
    return r;
  endfunction

  // model of the engine: updates the stores and queues the results a command causes
  task automatic apply_command(input etc_pkg::request_t r, input bit typed,
                               input logic signed [31:0] typed_value);
    longint acc;
    longint p;
    etc_pkg::result_t res;
    logic signed [31:0] tg [DIM];
    logic signed [31:0] sg [DIM];
    tg = '{r.test_grad_x, r.test_grad_y, r.test_grad_z};
    sg = '{r.shape_grad_x, r.shape_grad_y, r.shape_grad_z};
    case (r.command)
      etc_pkg::CMD_WRITE_TENSOR: begin
        n_writes++;
        if (r.idx_first < DIM && r.idx_second < DIM && r.idx_third < DIM &&
            r.idx_fourth < DIM)
          stiffness_mem[((r.idx_first * DIM + r.idx_second) * DIM + r.idx_third) * DIM
                        + r.idx_fourth] = r.entry_value;
      end
      etc_pkg::CMD_WRITE_OPERAND: begin
        n_writes++;
        if (r.idx_third < DIM && r.idx_fourth < DIM)
          operand_mem[r.idx_third * DIM + r.idx_fourth] = r.entry_value;
      end
      etc_pkg::CMD_CONTRACT: begin
        n_contracts++;
        for (int a = 0; a < DIM; a++) begin
          for (int b = 0; b < DIM; b++) begin
            acc = 0;
            for (int c = 0; c < DIM; c++)
              for (int d = 0; d < DIM; d++)
                acc += (longint'(stiffness_mem[((a * DIM + b) * DIM + c) * DIM + d]) *
                        longint'(operand_mem[c * DIM + d])) >>> 16;
            res.result_value = clamp32(acc);
            res.result_row = 2'(a);
            res.result_col = 2'(b);
            res.last = (a == DIM - 1) && (b == DIM - 1);
            pending_results.push_back(res);
          end
        end
      end
      default: begin
        n_jacobians++;
        acc = 0;
        if (r.idx_first < DIM && r.idx_third < DIM) begin
          for (int b = 0; b < DIM; b++) begin
            for (int d = 0; d < DIM; d++) begin
              p = clamp32((longint'(stiffness_mem[((r.idx_first * DIM + b) * DIM
                                                    + r.idx_third) * DIM + d]) *
                           longint'(sg[d])) >>> 16);
              acc += (p * longint'(tg[b])) >>> 16;
            end
          end
        end else begin
          n_outside++;
        end
        res.result_value = typed ? typed_value : clamp32(acc);
        res.result_row = r.idx_first;
        res.result_col = r.idx_third;
        res.last = 1'b1;
        pending_results.push_back(res);
      end
    endcase
  endtask

  // transfers on both sides, result checking and the watchdog
  always @(posedge clk) begin
    etc_pkg::result_t want;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (strobe === 1'b1) begin
        moved = 1'b1;
        n_checked++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: value %0d row %0d col %0d last %0d",
                 result.result_value, result.result_row, result.result_col, result.last);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   result.result_value);
            errors++;
          end
          if (result.result_row !== want.result_row) begin
            $error("result_row: expected %0d, got %0d", want.result_row, result.result_row);
            errors++;
          end
          if (result.result_col !== want.result_col) begin
            $error("result_col: expected %0d, got %0d", want.result_col, result.result_col);
            errors++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result.last);
            errors++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        moved = 1'b1;
        apply_command(request, step_typed, step_value);
      end
    end
    quiet = moved ? 0 : quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("elasticity_tensor_contraction: mismatch");
      $finish;
    end
  end

  // one command transfer, then a gap when the current burst runs out
  task automatic send(input etc_pkg::request_t r, input bit typed,
                      input logic signed [31:0] tv);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    step_typed <= typed;
    step_value <= tv;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    etc_pkg::request_t r;
    int pick;

    // slice i = 0, k = 0 at full scale, then the jacobian extremes
    for (int b = 0; b < DIM; b++)
      for (int d = 0; d < DIM; d++)
        directed_steps.push_back('{mk_req(etc_pkg::CMD_WRITE_TENSOR, 2'd0, 2'(b), 2'd0,
                                          2'(d), Q_MAX, '0, '0, '0, '0, '0, '0),
                                   1'b0, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_JACOBIAN, 2'd0, 2'd0, 2'd0, 2'd0, '0,
                                      Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
                               1'b1, Q_MAX});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_JACOBIAN, 2'd0, 2'd0, 2'd0, 2'd0, '0,
                                      Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN),
                               1'b1, Q_MIN});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_JACOBIAN, 2'd0, 2'd0, 2'd0, 2'd0, Q_MAX,
                                      '0, '0, '0, '0, '0, '0), 1'b1, '0});
    // jacobian index out of range
    directed_steps.push_back('{mk_req(etc_pkg::CMD_JACOBIAN, 2'd3, 2'd1, 2'd1, 2'd2, Q_MIN,
                                      Q_MAX, Q_ONE, Q_MIN, Q_ONE, Q_MAX, Q_MIN), 1'b1, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_JACOBIAN, 2'd2, 2'd0, 2'd3, 2'd0, '0,
                                      Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_ONE, Q_ONE), 1'b1, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_JACOBIAN, 2'd3, 2'd3, 2'd3, 2'd3, '0,
                                      Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1'b1, '0});
    // writes with an index out of range are dropped
    directed_steps.push_back('{mk_req(etc_pkg::CMD_WRITE_TENSOR, 2'd3, 2'd0, 2'd0, 2'd0,
                                      '0, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_WRITE_TENSOR, 2'd0, 2'd0, 2'd0, 2'd3,
                                      Q_MIN, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_WRITE_OPERAND, 2'd0, 2'd0, 2'd3, 2'd0,
                                      Q_MAX, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_WRITE_OPERAND, 2'd0, 2'd0, 2'd0, 2'd3,
                                      Q_MIN, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    // operand writes ignore i and j
    directed_steps.push_back('{mk_req(etc_pkg::CMD_WRITE_OPERAND, 2'd3, 2'd3, 2'd1, 2'd2,
                                      Q_MIN, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_WRITE_TENSOR, 2'd0, 2'd1, 2'd0, 2'd2,
                                      Q_MIN, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_JACOBIAN, 2'd0, 2'd0, 2'd0, 2'd0, '0,
                                      Q_ONE, -2 * Q_ONE, 32'sh0000_8000,
                                      -32'sh0000_4000, Q_ONE, 3 * Q_ONE), 1'b0, '0});
    directed_steps.push_back('{mk_req(etc_pkg::CMD_JACOBIAN, 2'd0, 2'd3, 2'd0, 2'd3, '0,
                                      32'sh0000_0001, -32'sh0000_0001, '0,
                                      32'sh0001_8000, -Q_ONE, 32'sh0000_0003), 1'b0, '0});

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[n])
      send(directed_steps[n].req, directed_steps[n].typed, directed_steps[n].value);

    // fill both stores so that every later read hits written entries
    for (int e = 0; e < DIM * DIM; e++)
      send(mk_req(etc_pkg::CMD_WRITE_OPERAND, rand_idx(), rand_idx(), 2'(e / DIM),
                  2'(e % DIM), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                  rand_q()), 1'b0, '0);
    for (int e = 0; e < DIM * DIM * DIM * DIM; e++)
      send(mk_req(etc_pkg::CMD_WRITE_TENSOR, 2'(e / 27), 2'((e / 9) % 3), 2'((e / 3) % 3),
                  2'(e % 3), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                  rand_q()), 1'b0, '0);

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      r = mk_req(etc_pkg::CMD_JACOBIAN, rand_idx(), rand_idx(), rand_idx(), rand_idx(),
                 rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
      if (pick < 30) r.command = etc_pkg::CMD_WRITE_TENSOR;
      else if (pick < 45) r.command = etc_pkg::CMD_WRITE_OPERAND;
      else if (pick < 70) r.command = etc_pkg::CMD_CONTRACT;
      send(r, 1'b0, '0);
      if (n == N_RANDOM / 2) begin
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("covered %0d writes, %0d contractions and %0d jacobians (%0d out of range)",
             n_writes, n_contracts, n_jacobians, n_outside);
    $display("%0d results checked, %0d errors", n_checked, errors);
    if (errors == 0) begin
      $display("elasticity_tensor_contraction: match");
    end else begin
      $display("elasticity_tensor_contraction: mismatch");
    end
    $finish;
  end

endmodule
